/* design/lso_pkg.sv */
package lso_pkg;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_SET   = 2'd1,
        KIND_FREE  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_FREE  = 2'd1,
        STATUS_NOT_USED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_SCAN,
        ST_SHIFT,
        ST_FINAL,
        ST_DONE
    } state_t;

    localparam int ID_W     = 8;
    localparam int REQ_W    = 10;
    localparam int EFF_W    = 9;
    localparam int VCOUNT_W = 9;

endpackage

/* design/lso_ram.sv */
module lso_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/layer_stack_order_manager.sv */
// An allocate scans the ids from the lowest up for a free one. A set or free that moves a layer
// shifts the entries in between one level over, one entry per cycle, then writes the layer's
// new level. Unknown kinds, out-of-range or unused ids and sets that keep their level move nothing.
// Throughput: one request at a time; the next is taken once the current result is queued.
// Reset: synchronous, active low; a clearing pass over all MAX_LAYERS entries follows, ready low.
module layer_stack_order_manager #(
    parameter int MAX_LAYERS = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_kind,
    input  logic [lso_pkg::ID_W-1:0]          s_layer_id,
    input  logic signed [lso_pkg::REQ_W-1:0]  s_requested_level,
    output logic                              m_valid,
    input  logic                              m_ready,
    output lso_pkg::status_t                  m_status,
    output logic [lso_pkg::ID_W-1:0]          m_result_id,
    output logic signed [lso_pkg::EFF_W-1:0]  m_effective_level,
    output logic [lso_pkg::VCOUNT_W-1:0]      m_visible_count,
    output logic                              m_redraw_needed
);

    import lso_pkg::*;

    localparam int IDW  = $clog2(MAX_LAYERS);
    localparam int LVW  = IDW + 1;
    localparam int INW  = LVW + 1;
    localparam int CW   = (IDW + 2 > REQ_W) ? IDW + 2 : REQ_W;
    localparam logic [IDW-1:0] LAST_IDX = IDW'(MAX_LAYERS - 1);

    // control
    state_t                 state_reg, state_next;
    logic [IDW-1:0]         clr_addr_reg, clr_addr_next;
    logic [IDW-1:0]         chk_reg, chk_next;
    logic [IDW-1:0]         rd_addr_reg, rd_addr_next;
    logic [IDW-1:0]         wr_addr_reg, wr_addr_next;
    logic [IDW:0]           rd_left_reg, rd_left_next;
    logic                   pend_reg, pend_next;
    logic                   dir_neg_reg, dir_neg_next;
    logic                   remove_reg, remove_next;
    logic                   insert_reg, insert_next;
    logic signed [LVW-1:0]  top_reg, top_next;
    logic                   m_valid_reg, m_valid_next;

    // payload
    logic [1:0]             kind_reg, kind_next;
    logic [IDW-1:0]         id_reg, id_next;
    logic signed [CW-1:0]   req_reg, req_next;
    logic signed [CW-1:0]   want_reg, want_next;
    status_t                res_status_reg, res_status_next;
    logic [ID_W-1:0]        res_id_reg, res_id_next;
    logic signed [CW-1:0]   res_eff_reg, res_eff_next;
    logic                   res_redraw_reg, res_redraw_next;
    status_t                m_status_reg, m_status_next;
    logic [ID_W-1:0]        m_result_id_reg, m_result_id_next;
    logic signed [EFF_W-1:0] m_eff_reg, m_eff_next;
    logic [VCOUNT_W-1:0]    m_vcount_reg, m_vcount_next;
    logic                   m_redraw_reg, m_redraw_next;

    // memories
    logic                   ina_we;
    logic [IDW-1:0]         ina_waddr, ina_raddr;
    logic [INW-1:0]         ina_wdata, ina_rdata;
    logic                   lal_we;
    logic [IDW-1:0]         lal_waddr, lal_raddr;
    logic [IDW-1:0]         lal_wdata, lal_rdata;

    // per-layer info: {used, level}
    lso_ram #(.DEPTH(MAX_LAYERS), .WIDTH(INW)) u_info_ram (
        .aclk  (aclk),
        .we    (ina_we),
        .waddr (ina_waddr),
        .wdata (ina_wdata),
        .raddr (ina_raddr),
        .rdata (ina_rdata)
    );

    // layer id shown at each level
    lso_ram #(.DEPTH(MAX_LAYERS), .WIDTH(IDW)) u_level_ram (
        .aclk  (aclk),
        .we    (lal_we),
        .waddr (lal_waddr),
        .wdata (lal_wdata),
        .raddr (lal_raddr),
        .rdata (lal_rdata)
    );

    // request decode
    logic [IDW+ID_W-1:0]    s_id_wide;
    logic [IDW-1:0]         s_id_idx;
    logic                   s_id_in_range;
    logic                   s_accept;

    assign s_id_wide     = {{IDW{1'b0}}, s_layer_id};
    assign s_id_idx      = s_id_wide[IDW-1:0];
    assign s_id_in_range = (int'(s_layer_id) < MAX_LAYERS);
    assign s_accept      = s_valid && s_ready;

    // move planning from the layer's stored info
    logic                   info_used;
    logic signed [LVW-1:0]  info_lvl;
    logic signed [CW-1:0]   old_c, top_c, lim_c, want_c, clamp_c;
    logic signed [CW-1:0]   wr_c, cnt_c;
    logic                   plan_dir_neg;

    assign info_used = ina_rdata[INW-1];
    assign info_lvl  = ina_rdata[LVW-1:0];
    assign old_c     = CW'(info_lvl);
    assign top_c     = CW'(top_reg);
    assign lim_c     = (old_c >= 0) ? top_c : top_c + CW'(1);

    always_comb begin
        clamp_c = (req_reg > lim_c) ? lim_c : req_reg;
        if (clamp_c < -1) begin
            clamp_c = CW'(-1);
        end
        want_c = (kind_reg == KIND_FREE) ? CW'(-1) : clamp_c;

        plan_dir_neg = 1'b0;
        wr_c         = old_c;
        cnt_c        = '0;
        if (old_c < 0) begin
            // insert: open a slot at the wanted level
            plan_dir_neg = 1'b1;
            wr_c         = top_c + CW'(1);
            cnt_c        = top_c - want_c + CW'(1);
        end else if (want_c < 0) begin
            // remove: close the gap up to the top
            cnt_c = top_c - old_c;
        end else if (old_c > want_c) begin
            plan_dir_neg = 1'b1;
            cnt_c        = old_c - want_c;
        end else begin
            cnt_c = want_c - old_c;
        end
    end

    logic [IDW+ID_W-1:0]    chk_wide;
    assign chk_wide = {{ID_W{1'b0}}, chk_reg};

    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        chk_next        = chk_reg;
        rd_addr_next    = rd_addr_reg;
        wr_addr_next    = wr_addr_reg;
        rd_left_next    = rd_left_reg;
        pend_next       = 1'b0;
        dir_neg_next    = dir_neg_reg;
        remove_next     = remove_reg;
        insert_next     = insert_reg;
        top_next        = top_reg;
        m_valid_next    = m_valid_reg;
        kind_next       = kind_reg;
        id_next         = id_reg;
        req_next        = req_reg;
        want_next       = want_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_eff_next    = res_eff_reg;
        res_redraw_next = res_redraw_reg;
        m_status_next   = m_status_reg;
        m_result_id_next = m_result_id_reg;
        m_eff_next      = m_eff_reg;
        m_vcount_next   = m_vcount_reg;
        m_redraw_next   = m_redraw_reg;

        ina_we    = 1'b0;
        ina_waddr = id_reg;
        ina_wdata = {1'b0, {LVW{1'b1}}};
        ina_raddr = chk_reg + IDW'(1);
        lal_we    = 1'b0;
        lal_waddr = wr_addr_reg;
        lal_wdata = lal_rdata;
        lal_raddr = rd_addr_reg;

        s_ready = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                ina_we    = 1'b1;
                ina_waddr = clr_addr_reg;
                ina_wdata = {1'b0, {LVW{1'b1}}};
                clr_addr_next = clr_addr_reg + IDW'(1);
                if (clr_addr_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                s_ready   = 1'b1;
                ina_raddr = (s_kind == KIND_ALLOC) ? '0 : s_id_idx;
                if (s_accept) begin
                    kind_next       = s_kind;
                    id_next         = s_id_idx;
                    req_next        = CW'(s_requested_level);
                    chk_next        = '0;
                    res_status_next = STATUS_NOT_USED;
                    res_id_next     = s_layer_id;
                    res_eff_next    = CW'(-1);
                    res_redraw_next = 1'b0;
                    if (s_kind == KIND_ALLOC) begin
                        state_next = ST_SCAN;
                    end else if ((s_kind == KIND_SET || s_kind == KIND_FREE)
                                 && s_id_in_range) begin
                        state_next = ST_EVAL;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_SCAN: begin
                // read data belongs to chk_reg; the next id is already being read
                if (!info_used) begin
                    ina_we          = 1'b1;
                    ina_waddr       = chk_reg;
                    ina_wdata       = {1'b1, {LVW{1'b1}}};
                    res_status_next = STATUS_OK;
                    res_id_next     = chk_wide[ID_W-1:0];
                    state_next      = ST_DONE;
                end else if (chk_reg == LAST_IDX) begin
                    res_status_next = STATUS_NO_FREE;
                    res_id_next     = '0;
                    state_next      = ST_DONE;
                end else begin
                    chk_next = chk_reg + IDW'(1);
                end
            end

            ST_EVAL: begin
                if (!info_used) begin
                    state_next = ST_DONE;
                end else if (kind_reg == KIND_FREE && old_c < 0) begin
                    // hidden layer: release only
                    ina_we          = 1'b1;
                    ina_waddr       = id_reg;
                    ina_wdata       = {1'b0, {LVW{1'b1}}};
                    res_status_next = STATUS_OK;
                    state_next      = ST_DONE;
                end else if (want_c == old_c) begin
                    res_status_next = STATUS_OK;
                    res_eff_next    = old_c;
                    state_next      = ST_DONE;
                end else begin
                    want_next    = want_c;
                    dir_neg_next = plan_dir_neg;
                    remove_next  = (want_c < 0);
                    insert_next  = (old_c < 0);
                    wr_addr_next = wr_c[IDW-1:0];
                    rd_addr_next = plan_dir_neg ? wr_c[IDW-1:0] - IDW'(1)
                                                : wr_c[IDW-1:0] + IDW'(1);
                    rd_left_next = cnt_c[IDW:0];
                    state_next   = ST_SHIFT;
                end
            end

            ST_SHIFT: begin
                if (rd_left_reg != '0) begin
                    lal_raddr    = rd_addr_reg;
                    rd_addr_next = dir_neg_reg ? rd_addr_reg - IDW'(1)
                                               : rd_addr_reg + IDW'(1);
                    rd_left_next = rd_left_reg - (IDW+1)'(1);
                    pend_next    = 1'b1;
                end
                // land the entry read last cycle one level over, renumber its layer
                if (pend_reg) begin
                    lal_we       = 1'b1;
                    lal_waddr    = wr_addr_reg;
                    lal_wdata    = lal_rdata;
                    ina_we       = 1'b1;
                    ina_waddr    = lal_rdata;
                    ina_wdata    = {1'b1, 1'b0, wr_addr_reg};
                    wr_addr_next = dir_neg_reg ? wr_addr_reg - IDW'(1)
                                               : wr_addr_reg + IDW'(1);
                end
                if (rd_left_reg == '0 && !pend_reg) begin
                    state_next = ST_FINAL;
                end
            end

            ST_FINAL: begin
                ina_we          = 1'b1;
                ina_waddr       = id_reg;
                res_status_next = STATUS_OK;
                res_redraw_next = 1'b1;
                if (remove_reg) begin
                    ina_wdata    = {kind_reg == KIND_SET, {LVW{1'b1}}};
                    top_next     = top_reg - LVW'(1);
                    res_eff_next = CW'(-1);
                end else begin
                    ina_wdata    = {1'b1, want_reg[LVW-1:0]};
                    lal_we       = 1'b1;
                    lal_waddr    = want_reg[IDW-1:0];
                    lal_wdata    = id_reg;
                    res_eff_next = want_reg;
                    if (insert_reg) begin
                        top_next = top_reg + LVW'(1);
                    end
                end
                state_next = ST_DONE;
            end

            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_status_next    = res_status_reg;
                    m_result_id_next = res_id_reg;
                    m_eff_next       = res_eff_reg[EFF_W-1:0];
                    m_vcount_next    = VCOUNT_W'(top_c + CW'(1));
                    m_redraw_next    = res_redraw_reg;
                    state_next       = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            chk_reg      <= '0;
            rd_addr_reg  <= '0;
            wr_addr_reg  <= '0;
            rd_left_reg  <= '0;
            pend_reg     <= 1'b0;
            dir_neg_reg  <= 1'b0;
            remove_reg   <= 1'b0;
            insert_reg   <= 1'b0;
            top_reg      <= '1;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            chk_reg      <= chk_next;
            rd_addr_reg  <= rd_addr_next;
            wr_addr_reg  <= wr_addr_next;
            rd_left_reg  <= rd_left_next;
            pend_reg     <= pend_next;
            dir_neg_reg  <= dir_neg_next;
            remove_reg   <= remove_next;
            insert_reg   <= insert_next;
            top_reg      <= top_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg        <= kind_next;
        id_reg          <= id_next;
        req_reg         <= req_next;
        want_reg        <= want_next;
        res_status_reg  <= res_status_next;
        res_id_reg      <= res_id_next;
        res_eff_reg     <= res_eff_next;
        res_redraw_reg  <= res_redraw_next;
        m_status_reg    <= m_status_next;
        m_result_id_reg <= m_result_id_next;
        m_eff_reg       <= m_eff_next;
        m_vcount_reg    <= m_vcount_next;
        m_redraw_reg    <= m_redraw_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_result_id       = m_result_id_reg;
    assign m_effective_level = m_eff_reg;
    assign m_visible_count   = m_vcount_reg;
    assign m_redraw_needed   = m_redraw_reg;

    a_clear_blocks: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("request taken during clearing pass");

    a_top_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (top_reg == $past(top_reg)) || (top_reg == $past(top_reg) + LVW'(1))
        || (top_reg == $past(top_reg) - LVW'(1)))
        else $error("top level moved by more than one");

    a_top_change_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (top_reg != $past(top_reg)) |-> ($past(state_reg) == ST_FINAL))
        else $error("top level changed outside the final write");

    a_redraw_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_redraw_needed) |-> (m_status == STATUS_OK))
        else $error("redraw flagged on a failed request");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result queued outside the done state");

    a_shift_reads_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT && rd_left_reg == '0 && !pend_reg) |=>
        (state_reg == ST_FINAL))
        else $error("shift did not hand over to the final write");

endmodule

/* tb/sv/layer_order_checker.sv */
`timescale 1ns / 1ps

module layer_order_checker #(
    parameter int MAX_LAYERS = 256
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_valid,
    input  logic                                      s_ready,
    input  logic [1:0]                                s_kind,
    input  logic [lso_pkg::ID_W-1:0]                  s_layer_id,
    input  logic signed [lso_pkg::REQ_W-1:0]          s_requested_level,
    input  logic                                      m_valid,
    input  logic                                      m_ready,
    input  lso_pkg::status_t                          m_status,
    input  logic [lso_pkg::ID_W-1:0]                  m_result_id,
    input  logic signed [lso_pkg::EFF_W-1:0]          m_effective_level,
    input  logic [lso_pkg::VCOUNT_W-1:0]              m_visible_count,
    input  logic                                      m_redraw_needed,
    output int                                        mismatches,
    output int                                        outstanding
);

    import lso_pkg::*;

    typedef struct {
        status_t                   status;
        logic [ID_W-1:0]           id;
        logic signed [EFF_W-1:0]   level;
        logic [VCOUNT_W-1:0]       shown;
        logic                      redraw;
    } stack_result_t;

    logic [ID_W-1:0] layer_at [MAX_LAYERS];
    int              level_of [MAX_LAYERS];
    bit              in_use   [MAX_LAYERS];
    int              top_lvl;
    stack_result_t   pending_results [$];

    function automatic void put_layer(input int lvl, input int id);
        if (lvl >= 0 && lvl < MAX_LAYERS && id < MAX_LAYERS) begin
            layer_at[lvl] = id[ID_W-1:0];
            level_of[id]  = lvl;
        end
    endfunction

    // Move a used layer to the wanted level; report whether the order changed.
    function automatic bit restack(input int id, input int want);
        int old;
        int lim;
        int k;
        old = level_of[id];
        lim = (old >= 0) ? top_lvl : top_lvl + 1;
        if (want > lim) want = lim;
        if (want < -1) want = -1;
        if (old == want) return 1'b0;
        if (old > want) begin
            if (want >= 0) begin
                for (k = old; k > want; k--) put_layer(k, int'(layer_at[k - 1]));
                put_layer(want, id);
            end else begin
                // remove: close the gap above, drop the top
                for (k = old; k < top_lvl; k++) put_layer(k, int'(layer_at[k + 1]));
                level_of[id] = -1;
                top_lvl--;
            end
        end else if (old >= 0) begin
            for (k = old; k < want; k++) put_layer(k, int'(layer_at[k + 1]));
            put_layer(want, id);
        end else begin
            // insert: open a slot by pushing everything at and above it up
            for (k = top_lvl; k >= want; k--) put_layer(k + 1, int'(layer_at[k]));
            put_layer(want, id);
            top_lvl++;
        end
        return 1'b1;
    endfunction

    function automatic stack_result_t next_stack_result(
        input logic [1:0]               kind,
        input logic [ID_W-1:0]          id,
        input logic signed [REQ_W-1:0]  req
    );
        stack_result_t r;
        int            idn;
        int            lv;
        idn      = int'(id);
        r.status = STATUS_OK;
        r.id     = id;
        r.level  = '1;
        r.redraw = 1'b0;
        case (kind)
            KIND_ALLOC: begin
                r.status = STATUS_NO_FREE;
                r.id     = '0;
                for (int i = 0; i < MAX_LAYERS; i++) begin
                    if (!in_use[i]) begin
                        in_use[i]   = 1'b1;
                        level_of[i] = -1;
                        r.status    = STATUS_OK;
                        r.id        = i[ID_W-1:0];
                        break;
                    end
                end
            end
            KIND_SET, KIND_FREE: begin
                if (idn < MAX_LAYERS && in_use[idn]) begin
                    if (kind == KIND_SET) begin
                        r.redraw = restack(idn, int'(req));
                        lv       = level_of[idn];
                        r.level  = lv[EFF_W-1:0];
                    end else begin
                        // hide first, even at level 0
                        if (level_of[idn] >= 0) r.redraw = restack(idn, -1);
                        in_use[idn] = 1'b0;
                    end
                end else begin
                    r.status = STATUS_NOT_USED;
                end
            end
            default: r.status = STATUS_NOT_USED;
        endcase
        lv      = top_lvl + 1;
        r.shown = lv[VCOUNT_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] want_v,
                               input logic signed [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        stack_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < MAX_LAYERS; i++) in_use[i] = 1'b0;
            top_lvl = -1;
            pending_results.delete();
        end else begin
            if (s_valid && s_ready)
                pending_results.push_back(
                    next_stack_result(s_kind, s_layer_id, s_requested_level));
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, m_status);
                    check_field("result_id", want.id, m_result_id);
                    check_field("effective_level", want.level, m_effective_level);
                    check_field("visible_count", want.shown, m_visible_count);
                    check_field("redraw_needed", want.redraw, m_redraw_needed);
                end
            end
        end
        outstanding = pending_results.size();
    end

endmodule

/* tb/sv/layer_stack_order_manager_tb.sv */
`timescale 1ns / 1ps

module layer_stack_order_manager_tb;

    import lso_pkg::*;

    localparam int         MAX_LAYERS   = 256;
    localparam logic [1:0] KIND_BOGUS   = 2'd3;
    localparam int         RANDOM_ITEMS = 1100;
    localparam int         RANDOM_POOL  = 23;
    localparam int         DRAIN_CYCLES = MAX_LAYERS + 16;
    localparam longint     CYCLE_LIMIT  = 3000000;

    logic                       aclk              = 1'b0;
    logic                       aresetn           = 1'b0;
    logic                       s_valid           = 1'b0;
    logic [1:0]                 s_kind            = '0;
    logic [ID_W-1:0]            s_layer_id        = '0;
    logic signed [REQ_W-1:0]    s_requested_level = '0;
    logic                       m_ready           = 1'b0;
    logic                       s_ready;
    logic                       m_valid;
    status_t                    m_status;
    logic [ID_W-1:0]            m_result_id;
    logic signed [EFF_W-1:0]    m_effective_level;
    logic [VCOUNT_W-1:0]        m_visible_count;
    logic                       m_redraw_needed;

    int     mismatches;
    int     outstanding;
    int     gap_pct    = 0;
    int     stall_pct  = 0;
    int     gap_calm   = 0;
    int     stall_calm = 0;
    longint cycles     = 0;

    layer_stack_order_manager #(
        .MAX_LAYERS(MAX_LAYERS)
    ) uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_layer_id        (s_layer_id),
        .s_requested_level (s_requested_level),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_result_id       (m_result_id),
        .m_effective_level (m_effective_level),
        .m_visible_count   (m_visible_count),
        .m_redraw_needed   (m_redraw_needed)
    );

    layer_order_checker #(
        .MAX_LAYERS(MAX_LAYERS)
    ) u_order_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_layer_id        (s_layer_id),
        .s_requested_level (s_requested_level),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_result_id       (m_result_id),
        .m_effective_level (m_effective_level),
        .m_visible_count   (m_visible_count),
        .m_redraw_needed   (m_redraw_needed),
        .mismatches        (mismatches),
        .outstanding       (outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stall the result channel, with occasional stretches of steady ready.
    always @(negedge aclk) begin
        if (stall_calm > 0) begin
            stall_calm <= stall_calm - 1;
            m_ready    <= 1'b1;
        end else begin
            if ($urandom_range(63) == 0) stall_calm <= $urandom_range(40, 10);
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic signed [REQ_W-1:0] req_level(input int v);
        return v[REQ_W-1:0];
    endfunction

    // Call at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_req(input logic [1:0] kind, input logic [ID_W-1:0] id,
                            input logic signed [REQ_W-1:0] lvl);
        logic took;
        if (gap_calm > 0) begin
            gap_calm--;
        end else begin
            if ($urandom_range(63) == 0) gap_calm = $urandom_range(40, 10);
            while ($urandom_range(99) < gap_pct) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_valid           <= 1'b1;
        s_kind            <= kind;
        s_layer_id        <= id;
        s_requested_level <= lvl;
        do begin
            @(posedge aclk);
            took = s_ready;
            @(negedge aclk);
        end while (!took);
    endtask

    // Mostly small ids so requests land on layers that are in use.
    task automatic send_random();
        int              pick;
        int              v;
        logic [1:0]      kind;
        logic [ID_W-1:0] id;
        pick = $urandom_range(99);
        if (pick < 25)      kind = KIND_ALLOC;
        else if (pick < 68) kind = KIND_SET;
        else if (pick < 95) kind = KIND_FREE;
        else                kind = KIND_BOGUS;
        if ($urandom_range(9) == 0) id = ID_W'($urandom_range(255));
        else                        id = ID_W'($urandom_range(RANDOM_POOL));
        if ($urandom_range(7) == 0) v = int'($urandom_range(1023)) - 512;
        else                        v = int'($urandom_range(RANDOM_POOL + 3)) - 2;
        send_req(kind, id, req_level(v));
    endtask

    initial begin
        int v;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: rejects, clamps, lift, lower, insert, remove, free at level 0
        send_req(KIND_SET,   8'd0,   req_level(0));
        send_req(KIND_FREE,  8'd255, req_level(0));
        send_req(KIND_BOGUS, 8'd128, req_level(-512));
        send_req(KIND_ALLOC, 8'd255, req_level(511));
        send_req(KIND_ALLOC, 8'd0,   req_level(-1));
        send_req(KIND_ALLOC, 8'd7,   req_level(0));
        send_req(KIND_SET,   8'd0,   req_level(511));
        send_req(KIND_SET,   8'd1,   req_level(-512));
        send_req(KIND_SET,   8'd1,   req_level(0));
        send_req(KIND_SET,   8'd2,   req_level(256));
        send_req(KIND_SET,   8'd2,   req_level(256));
        send_req(KIND_SET,   8'd2,   req_level(0));
        send_req(KIND_SET,   8'd1,   req_level(2));
        send_req(KIND_SET,   8'd0,   req_level(-1));
        send_req(KIND_FREE,  8'd2,   req_level(5));
        send_req(KIND_FREE,  8'd1,   req_level(0));
        send_req(KIND_ALLOC, 8'd0,   req_level(0));
        send_req(KIND_FREE,  8'd0,   req_level(0));
        send_req(KIND_FREE,  8'd0,   req_level(0));
        send_req(KIND_SET,   8'd255, req_level(255));
        send_req(KIND_SET,   8'd1,   req_level(-1));
        send_req(KIND_FREE,  8'd1,   req_level(0));

        // fill every layer, one past full, then show them all
        repeat (MAX_LAYERS + 1)
            send_req(KIND_ALLOC, ID_W'($urandom_range(255)),
                     req_level($urandom_range(1023)));
        for (int i = 0; i < MAX_LAYERS; i++)
            send_req(KIND_SET, ID_W'(i), req_level($urandom_range(511, 256)));
        // long shifts through a full table
        repeat (60) begin
            if ($urandom_range(4) == 0) v = -1 - int'($urandom_range(3));
            else                        v = int'($urandom_range(300));
            send_req(KIND_SET, ID_W'($urandom_range(255)), req_level(v));
        end
        for (int i = 0; i < MAX_LAYERS; i++)
            send_req(KIND_FREE, ID_W'((i * 167 + 13) % MAX_LAYERS),
                     req_level($urandom_range(1023)));

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 81; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 81; end
                default: begin gap_pct = 35; stall_pct = 35; end
            endcase
            repeat (RANDOM_ITEMS / 4) send_random();
        end
        s_valid <= 1'b0;

        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
design/lso_pkg.sv
design/lso_ram.sv
design/layer_stack_order_manager.sv
tb/sv/layer_order_checker.sv
tb/sv/layer_stack_order_manager_tb.sv
